@@ hw/rtl/periodic_timer_bank_defines.svh @@
// Assertion macros for the periodic timer bank controller RTL.
`ifndef PERIODIC_TIMER_BANK_DEFINES_SVH
`define PERIODIC_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, switched off while rst_ni is low.
`define PTB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, switched off while rst_ni is low.
`define PTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ptb_pkg.sv @@
// Types and constants shared by the periodic timer bank modules.
package ptb_pkg;

  localparam int unsigned CmdW      = 1;
  localparam int unsigned SlotIdxW  = 3;
  localparam int unsigned ReloadW   = 16;
  localparam int unsigned TypeW     = 8;
  localparam int unsigned FiredIdxW = 3;

  // At most this many firings are reported for one tick.
  localparam int unsigned ResultLimit = 8;
  localparam int unsigned NumFiredW   = 4;

  localparam logic [CmdW-1:0] CMD_TICK = 1'b0;
  localparam logic [CmdW-1:0] CMD_LOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } ptb_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // write one slot from the input item
    logic start;   // a tick begins: clear the firing count
    logic rd_en;   // read the slot at the read address
    logic commit;  // update the slot held in the evaluation registers
    logic flush;   // move the pending firing out as the last of the tick
  } ptb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit;      // slot under evaluation fires and will be reported
    logic pend_vld;  // a firing is waiting in the pending register
    logic out_free;  // the output register can take a firing this cycle
  } ptb_status_t;

endpackage

@@ hw/rtl/ptb_in_if.sv @@
// Input channel of the periodic timer bank: ticks and slot loads.
interface ptb_in_if;
  logic                                valid;
  logic                                ready;
  logic [ptb_pkg::CmdW-1:0]            command;
  logic [ptb_pkg::SlotIdxW-1:0]        slot_index;
  logic [ptb_pkg::ReloadW-1:0]         reload_value;
  logic [ptb_pkg::TypeW-1:0]           message_type;

  modport source (output valid, output command, output slot_index,
                  output reload_value, output message_type, input ready);
  modport sink   (input valid, input command, input slot_index,
                  input reload_value, input message_type, output ready);
endinterface

@@ hw/rtl/ptb_out_if.sv @@
// Output channel of the periodic timer bank: one item per reported timer firing.
interface ptb_out_if;
  logic                           valid;
  logic                           ready;
  logic [ptb_pkg::TypeW-1:0]      fired_type;
  logic [ptb_pkg::FiredIdxW-1:0]  fired_index;
  logic                           last;

  modport source (output valid, output fired_type, output fired_index,
                  output last, input ready);
  modport sink   (input valid, input fired_type, input fired_index,
                  input last, output ready);
endinterface

@@ hw/rtl/periodic_timer_bank.sv @@
// Top level of the periodic timer bank: a controller and a datapath joined by commands.
//
// A bank of NUM_SLOTS periodic timers, each holding a reload value, a down-count
// and an 8-bit message type. An item with command load writes one slot's
// reload value and count (both from reload_value, cut to COUNT_BITS) and its
// type; a load to an index beyond the bank is dropped. A reload value of zero
// leaves the slot disabled. An item with command tick makes the block visit
// every slot in index order, one slot per cycle while the scan is not held
// for a full output register, through the registered read port of the slot
// stores: an enabled slot with a nonzero count counts down, and one at zero
// reloads and fires, so a slot fires every reload+1 ticks. Each firing leaves
// as one output item with the slot's type and its index (low three bits),
// lowest index first, and the last firing of a tick carries last set; a tick
// with no firing produces no item. At most eight firings are reported per
// tick, and further slots still reload. Because last can only be known once
// the next firing or the end of the scan is seen, each firing waits in a
// pending register before it moves to the output register. A new item is
// accepted only once the scan and flush of a tick are done; the scan is held
// while a full output register is held by the consumer. The final firing of
// a tick may still wait at the output while the next item is taken. After
// reset every slot is disabled at once; there is no clearing pass.
module periodic_timer_bank #(
  parameter int unsigned NUM_SLOTS  = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ptb_in_if.sink             item_i,
  ptb_out_if.source          fired_o
);

  // Width of a slot address; a one-slot bank still uses one address bit.
  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  ptb_pkg::ptb_cmd_t    cmd;
  ptb_pkg::ptb_status_t status;
  logic [IW-1:0]        rd_addr;

  // The controller owns the input handshake and the scan sequence.
  ptb_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .IW        (IW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .command_i  (item_i.command),
    .status_i   (status),
    .in_ready_o (item_i.ready),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  // The datapath holds the slot stores and drives the output channel.
  ptb_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .IW         (IW)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .slot_index_i   (item_i.slot_index),
    .reload_value_i (item_i.reload_value),
    .message_type_i (item_i.message_type),
    .out_ready_i    (fired_o.ready),
    .status_o       (status),
    .out_valid_o    (fired_o.valid),
    .fired_type_o   (fired_o.fired_type),
    .fired_index_o  (fired_o.fired_index),
    .last_o         (fired_o.last)
  );

endmodule

@@ hw/rtl/ptb_datapath.sv @@
// Slot stores, slot evaluation, pending firing and output register.
module ptb_datapath #(
  parameter int unsigned NUM_SLOTS  = 8,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned IW         = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ptb_pkg::ptb_cmd_t                 cmd_i,
  input  logic [IW-1:0]                     rd_addr_i,
  input  logic [ptb_pkg::SlotIdxW-1:0]      slot_index_i,
  input  logic [ptb_pkg::ReloadW-1:0]       reload_value_i,
  input  logic [ptb_pkg::TypeW-1:0]         message_type_i,
  input  logic                              out_ready_i,
  output ptb_pkg::ptb_status_t              status_o,
  output logic                              out_valid_o,
  output logic [ptb_pkg::TypeW-1:0]         fired_type_o,
  output logic [ptb_pkg::FiredIdxW-1:0]     fired_index_o,
  output logic                              last_o
);

  localparam int unsigned XW = IW + ptb_pkg::SlotIdxW;

  logic [COUNT_BITS-1:0]          reload_mem [NUM_SLOTS];
  logic [COUNT_BITS-1:0]          count_mem  [NUM_SLOTS];
  logic [ptb_pkg::TypeW-1:0]      type_mem   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]           slot_vld_q;

  logic [XW-1:0]                  ld_wide;
  logic                           ld_hit;
  logic [IW-1:0]                  ld_addr;
  logic [COUNT_BITS-1:0]          ld_value;

  logic [COUNT_BITS-1:0]          rel_rd_q;
  logic [COUNT_BITS-1:0]          cnt_rd_q;
  logic [ptb_pkg::TypeW-1:0]      typ_rd_q;
  logic [IW-1:0]                  ev_idx_q;
  logic [XW-1:0]                  ev_idx_wide;

  logic                           ev_enabled;
  logic                           ev_fires;
  logic [COUNT_BITS-1:0]          cnt_next;

  logic [ptb_pkg::NumFiredW-1:0]  n_q;
  logic                           push;
  logic                           move_out;

  logic                           pend_vld_q;
  logic [ptb_pkg::TypeW-1:0]      pend_type_q;
  logic [ptb_pkg::FiredIdxW-1:0]  pend_idx_q;

  logic                           out_vld_q;
  logic [ptb_pkg::TypeW-1:0]      out_type_q;
  logic [ptb_pkg::FiredIdxW-1:0]  out_idx_q;
  logic                           out_last_q;

  // Loads to a slot index beyond the bank are dropped.
  assign ld_wide  = XW'(slot_index_i);
  assign ld_hit   = cmd_i.load && (ld_wide < XW'(NUM_SLOTS));
  assign ld_addr  = ld_wide[IW-1:0];
  assign ld_value = COUNT_BITS'(reload_value_i);

  assign ev_idx_wide = XW'(ev_idx_q);
  assign ev_enabled  = (rel_rd_q != '0);
  assign ev_fires    = ev_enabled && (cnt_rd_q == '0);
  assign cnt_next    = ev_fires ? rel_rd_q : (cnt_rd_q - COUNT_BITS'(1));

  assign status_o.emit     = ev_fires && (n_q < ptb_pkg::NumFiredW'(ptb_pkg::ResultLimit));
  assign status_o.pend_vld = pend_vld_q;
  assign status_o.out_free = !out_vld_q || out_ready_i;

  assign push     = cmd_i.commit && status_o.emit;
  assign move_out = (push && pend_vld_q) || cmd_i.flush;

  // Slot stores: one write port, one registered read port. A slot that was
  // never loaded reads as zero, which leaves it disabled.
  always_ff @(posedge clk_i) begin
    if (ld_hit) begin
      reload_mem[ld_addr] <= ld_value;
      count_mem[ld_addr]  <= ld_value;
      type_mem[ld_addr]   <= message_type_i;
    end else if (cmd_i.commit && ev_enabled) begin
      count_mem[ev_idx_q] <= cnt_next;
    end
    if (cmd_i.rd_en) begin
      ev_idx_q <= rd_addr_i;
      if (slot_vld_q[rd_addr_i]) begin
        rel_rd_q <= reload_mem[rd_addr_i];
        cnt_rd_q <= count_mem[rd_addr_i];
        typ_rd_q <= type_mem[rd_addr_i];
      end else begin
        rel_rd_q <= '0;
        cnt_rd_q <= '0;
        typ_rd_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      n_q        <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (ld_hit) begin
        slot_vld_q[ld_addr] <= 1'b1;
      end
      if (cmd_i.start) begin
        n_q <= '0;
      end else if (push) begin
        n_q <= n_q + ptb_pkg::NumFiredW'(1);
      end
      if (push) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_vld_q <= 1'b0;
      end
      if (move_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      pend_type_q <= typ_rd_q;
      pend_idx_q  <= ev_idx_wide[ptb_pkg::FiredIdxW-1:0];
    end
    if (move_out) begin
      out_type_q <= pend_type_q;
      out_idx_q  <= pend_idx_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign fired_type_o  = out_type_q;
  assign fired_index_o = out_idx_q;
  assign last_o        = out_last_q;

endmodule

@@ hw/rtl/ptb_ctrl.sv @@
// Controller of the periodic timer bank: accepts items and sequences the slot scan.
`include "periodic_timer_bank_defines.svh"

module ptb_ctrl #(
  parameter int unsigned NUM_SLOTS = 8,
  parameter int unsigned IW        = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [ptb_pkg::CmdW-1:0]     command_i,
  input  ptb_pkg::ptb_status_t         status_i,
  output logic                         in_ready_o,
  output ptb_pkg::ptb_cmd_t            cmd_o,
  output logic [IW-1:0]                rd_addr_o
);

  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

  ptb_pkg::ptb_state_e state_q, state_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic                ev_q, ev_d;
  logic                stall;

  assign rd_addr_o = idx_q[IW-1:0];

  // A firing can only enter the pending register when the previous one can
  // move on to the output register.
  assign stall = ev_q && status_i.emit && status_i.pend_vld && !status_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptb_pkg::ST_IDLE;
      idx_q   <= '0;
      ev_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ev_q    <= ev_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    ev_d       = ev_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ptb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (command_i == ptb_pkg::CMD_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            idx_d       = '0;
            ev_d        = 1'b0;
            state_d     = ptb_pkg::ST_SCAN;
          end
        end
      end
      ptb_pkg::ST_SCAN: begin
        if (!stall) begin
          cmd_o.commit = ev_q;
          if (idx_q < CW'(NUM_SLOTS)) begin
            cmd_o.rd_en = 1'b1;
            idx_d       = idx_q + CW'(1);
            ev_d        = 1'b1;
          end else begin
            ev_d    = 1'b0;
            state_d = ptb_pkg::ST_FLUSH;
          end
        end
      end
      ptb_pkg::ST_FLUSH: begin
        if (!status_i.pend_vld) begin
          state_d = ptb_pkg::ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ptb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptb_pkg::ST_IDLE;
      end
    endcase
  end

  `PTB_ASSERT_IMPL(a_idle_no_pending, state_q == ptb_pkg::ST_IDLE, !status_i.pend_vld, "pending firing left over after a tick")
  `PTB_ASSERT_IMPL(a_commit_needs_eval, cmd_o.commit, ev_q, "slot update without a slot under evaluation")
  `PTB_ASSERT_IMPL(a_idx_range, 1'b1, idx_q <= CW'(NUM_SLOTS), "scan index beyond the bank")
  `PTB_ASSERT_NEXT(a_tick_starts_scan, in_valid_i && in_ready_o && (command_i == ptb_pkg::CMD_TICK), state_q == ptb_pkg::ST_SCAN, "accepted tick did not start a scan")

endmodule

@@ bench/ptb_fire_checker.sv @@
// Checker for the periodic timer bank: predicts every firing and compares the output items.
`timescale 1ns / 1ps

module ptb_fire_checker #(
  parameter int unsigned NUM_SLOTS  = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptb_in_if           item_i,
  ptb_out_if          fired_i,
  output int unsigned mismatch_count_o,
  output int unsigned awaited_count_o,
  output int unsigned checked_count_o
);
  import ptb_pkg::*;

  typedef struct packed {
    logic [TypeW-1:0]     fired_type;
    logic [FiredIdxW-1:0] fired_index;
    logic                 last;
  } firing_t;

  logic [COUNT_BITS-1:0] slot_reload [NUM_SLOTS];
  logic [COUNT_BITS-1:0] slot_count  [NUM_SLOTS];
  logic [TypeW-1:0]      slot_type   [NUM_SLOTS];
  firing_t               firing_queue [$];

  function automatic void load_slot(logic [SlotIdxW-1:0] idx, logic [ReloadW-1:0] rel,
                                    logic [TypeW-1:0] typ);
    if (idx < NUM_SLOTS) begin
      slot_reload[idx] = rel[COUNT_BITS-1:0];
      slot_count[idx]  = rel[COUNT_BITS-1:0];
      slot_type[idx]   = typ;
    end
  endfunction

  // Walk the slots in index order; a slot at zero reloads and fires.
  function automatic void advance_tick();
    firing_t this_tick [$];
    firing_t f;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (slot_reload[s] != '0) begin
        if (slot_count[s] != '0) begin
          slot_count[s] = slot_count[s] - 1'b1;
        end else begin
          slot_count[s] = slot_reload[s];
          if (this_tick.size() < ResultLimit) begin
            f.fired_type  = slot_type[s];
            f.fired_index = FiredIdxW'(s);
            f.last        = 1'b0;
            this_tick.push_back(f);
          end
        end
      end
    end
    if (this_tick.size() > 0) this_tick[this_tick.size()-1].last = 1'b1;
    foreach (this_tick[i]) firing_queue.push_back(this_tick[i]);
  endfunction

  function automatic void compare_firing();
    firing_t want;
    checked_count_o++;
    if (firing_queue.size() == 0) begin
      $error("firing with none expected: fired_type %0d, fired_index %0d, last %0d",
             fired_i.fired_type, fired_i.fired_index, fired_i.last);
      mismatch_count_o++;
      return;
    end
    want = firing_queue.pop_front();
    if (fired_i.fired_type !== want.fired_type) begin
      $error("fired_type: expected %0d, got %0d", want.fired_type, fired_i.fired_type);
      mismatch_count_o++;
    end
    if (fired_i.fired_index !== want.fired_index) begin
      $error("fired_index: expected %0d, got %0d", want.fired_index, fired_i.fired_index);
      mismatch_count_o++;
    end
    if (fired_i.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, fired_i.last);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_reload[s] = '0;
        slot_count[s]  = '0;
        slot_type[s]   = '0;
      end
      firing_queue.delete();
      mismatch_count_o = 0;
      checked_count_o  = 0;
    end else begin
      // Outputs first: the last firing of one tick may leave as the next item enters.
      if (fired_i.valid && fired_i.ready) compare_firing();
      if (item_i.valid && item_i.ready) begin
        if (item_i.command == CMD_LOAD) begin
          load_slot(item_i.slot_index, item_i.reload_value, item_i.message_type);
        end else begin
          advance_tick();
        end
      end
    end
    awaited_count_o = firing_queue.size();
  end

  final begin
    if (firing_queue.size() != 0) $error("%0d firings never arrived", firing_queue.size());
  end

endmodule

@@ bench/tb_periodic_timer_bank.sv @@
// Top of the periodic timer bank testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_periodic_timer_bank;
  import ptb_pkg::*;

  localparam int unsigned NumSlots    = 8;
  localparam int unsigned CountBits   = 16;
  // Random items per pacing phase; with the directed items the run sends about
  // three hundred and ten.
  localparam int unsigned PhaseItems  = 94;
  // The drain wait allows twice the time that a tick needs without stalls.
  localparam int unsigned DrainCycles = 2 * (NumSlots + 3);
  // Far beyond the slowest correct run: eight firings per tick, each held by
  // a receiver that stalls most cycles, plus the sender's gaps.
  localparam int unsigned CycleLimit  = 400000;

  logic clk_i;
  logic rst_ni;

  ptb_in_if  item_if ();
  ptb_out_if fired_if ();

  int unsigned mismatch_count;
  int unsigned awaited_count;
  int unsigned checked_count;
  int unsigned cycle_count;
  int unsigned load_count;
  int unsigned tick_count;

  // Chance out of a hundred that the sender holds back an item, and that the
  // receiver drops ready, in the current cycle.
  int unsigned send_gap_pct;
  int unsigned take_gap_pct;

  periodic_timer_bank #(
    .NUM_SLOTS  (NumSlots),
    .COUNT_BITS (CountBits)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .fired_o (fired_if)
  );

  ptb_fire_checker #(
    .NUM_SLOTS  (NumSlots),
    .COUNT_BITS (CountBits)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item_if),
    .fired_i          (fired_if),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count),
    .checked_count_o  (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The receiver decides afresh at every falling edge whether to take a firing.
  always @(negedge clk_i) begin
    fired_if.ready <= ($urandom_range(99) >= take_gap_pct);
  end

  // A run that hangs is cut off here and counted as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_periodic_timer_bank NOT OK");
      $finish;
    end
  end

  // Offers one item from a falling edge and holds it until the block takes it.
  // Random gaps come before the item, so valid is only lowered on a gap and
  // stays high between items sent back to back.
  task automatic send_item(logic [CmdW-1:0] cmd, logic [SlotIdxW-1:0] idx,
                           logic [ReloadW-1:0] rel, logic [TypeW-1:0] typ);
    while ($urandom_range(99) < send_gap_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid        <= 1'b1;
    item_if.command      <= cmd;
    item_if.slot_index   <= idx;
    item_if.reload_value <= rel;
    item_if.message_type <= typ;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    if (cmd == CMD_LOAD) load_count++;
    else tick_count++;
    @(negedge clk_i);
  endtask

  // Mostly ticks, so that short periods fire often; loads keep rewriting the
  // slots with short periods, with the odd disable and the odd full-width one.
  // On a tick the other fields carry noise, which the block must ignore.
  task automatic send_random_item();
    logic [ReloadW-1:0] rel;
    int unsigned        roll;
    if ($urandom_range(99) < 64) begin
      send_item(CMD_TICK, SlotIdxW'($urandom_range(7)), ReloadW'($urandom),
                TypeW'($urandom));
    end else begin
      roll = $urandom_range(9);
      if (roll == 0) rel = '0;
      else if (roll < 8) rel = ReloadW'($urandom_range(6, 1));
      else rel = ReloadW'($urandom);
      send_item(CMD_LOAD, SlotIdxW'($urandom_range(7)), rel, TypeW'($urandom));
    end
  endtask

  initial begin
    item_if.valid        = 1'b0;
    item_if.command      = CMD_TICK;
    item_if.slot_index   = '0;
    item_if.reload_value = '0;
    item_if.message_type = '0;
    fired_if.ready       = 1'b0;
    cycle_count          = 0;
    load_count           = 0;
    tick_count           = 0;
    send_gap_pct         = 9;
    take_gap_pct         = 71;
    rst_ni               = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. A tick on an empty bank must produce nothing.
    send_item(CMD_TICK, '0, '0, '0);
    // Every slot with a period of two ticks, so all eight fire on one tick,
    // lowest index first, with last only on slot seven.
    for (int s = 0; s < NumSlots; s++) begin
      send_item(CMD_LOAD, SlotIdxW'(s), 16'd1, (s == 0) ? 8'hFF : TypeW'(s * 37));
    end
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_TICK, '0, '0, '0);
    // The largest period, a disabled slot, and a period of three on slot zero.
    send_item(CMD_LOAD, 3'd7, 16'hFFFF, 8'hA5);
    send_item(CMD_LOAD, 3'd3, 16'h0000, 8'h5A);
    send_item(CMD_LOAD, 3'd0, 16'd2, 8'h00);
    repeat (4) send_item(CMD_TICK, 3'd7, 16'hFFFF, 8'hFF);
    // Reload of zero on every slot silences the bank entirely.
    for (int s = 0; s < NumSlots; s++) send_item(CMD_LOAD, SlotIdxW'(s), '0, '0);
    send_item(CMD_TICK, '0, '0, '0);

    // Random part in three pacing phases: a slow receiver, then a slow sender,
    // then both at full rate.
    repeat (PhaseItems) send_random_item();
    send_gap_pct = 71;
    take_gap_pct = 9;
    repeat (PhaseItems) send_random_item();
    send_gap_pct = 0;
    take_gap_pct = 0;
    repeat (PhaseItems) send_random_item();
    item_if.valid <= 1'b0;

    // Wait for every predicted firing, then a little longer so that a stray
    // extra item from the block would still be seen.
    while (awaited_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Covered %0d slot loads and %0d ticks over three pacing phases.",
             load_count, tick_count);
    $display("Compared %0d timer firings field by field.", checked_count);
    if (mismatch_count == 0) begin
      $display("tb_periodic_timer_bank OK");
    end else begin
      $display("tb_periodic_timer_bank NOT OK");
    end
    $finish;
  end

endmodule
